@@ design/fscl_pkg.sv @@
package fscl_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_PROG_HIGH = 4'd1,
    PH_SETTLE_A  = 4'd2,
    PH_INIT_LOW  = 4'd3,
    PH_SETTLE_B  = 4'd4,
    PH_INIT_HIGH = 4'd5,
    PH_LOAD      = 4'd6,
    PH_DONE_LOW  = 4'd7,
    PH_DONE_HIGH = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_START  = 2'd1,
    MODE_BYTE   = 2'd2,
    MODE_FINISH = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_PROG_HIGH   = 3'd0,
    REG_SETTLE      = 3'd1,
    REG_INIT_LOW    = 3'd2,
    REG_INIT_HIGH   = 3'd3,
    REG_DONE_LIMIT  = 3'd4
  } reg_idx_e;

  localparam logic [2:0] StatusNone      = 3'd0;
  localparam logic [2:0] StatusOk        = 3'd1;
  localparam logic [2:0] StatusInitLowTo = 3'd2;
  localparam logic [2:0] StatusInitHiTo  = 3'd3;
  localparam logic [2:0] StatusDoneTo    = 3'd4;

  typedef struct packed {
    logic [7:0]  prog_high_ticks;
    logic [7:0]  settle_ticks;
    logic [15:0] init_low_timeout;
    logic [23:0] init_high_timeout;
    logic [7:0]  done_clock_limit;
  } cfg_t;

endpackage

@@ design/fscl_regs.sv @@
module fscl_regs
  import fscl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[CfgAddrW-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prog_high_ticks   <= 8'd10;
      cfg_q.settle_ticks      <= 8'd5;
      cfg_q.init_low_timeout  <= 16'd200;
      cfg_q.init_high_timeout <= 24'hFFFFFF;
      cfg_q.done_clock_limit  <= 8'd50;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROG_HIGH:  cfg_q.prog_high_ticks   <= pwdata[7:0];
        REG_SETTLE:     cfg_q.settle_ticks      <= pwdata[7:0];
        REG_INIT_LOW:   cfg_q.init_low_timeout  <= pwdata[15:0];
        REG_INIT_HIGH:  cfg_q.init_high_timeout <= pwdata[23:0];
        REG_DONE_LIMIT: cfg_q.done_clock_limit  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROG_HIGH:  prdata = {24'd0, cfg_q.prog_high_ticks};
      REG_SETTLE:     prdata = {24'd0, cfg_q.settle_ticks};
      REG_INIT_LOW:   prdata = {16'd0, cfg_q.init_low_timeout};
      REG_INIT_HIGH:  prdata = {8'd0, cfg_q.init_high_timeout};
      REG_DONE_LIMIT: prdata = {24'd0, cfg_q.done_clock_limit};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ design/fpga_serial_config_loader.sv @@
// Slave-serial FPGA configuration loader.
// Input channel (in_valid_i/in_ready_o): one item per pin tick, carrying a
// mode (tick, start, bitstream byte, finish) and the sampled init and done
// pins. Output channel (out_valid_o/out_ready_i): one result item per input
// item with the driven prog/clock/data levels, ready_for_byte, busy, a
// rejected flag and the sticky status of the last sequence.
// The result of an item is in the output register the cycle after it is
// accepted. Throughput is one item per cycle while the receiver takes each
// result; the sequencer state advances in the same cycle as the item is
// taken and the output register takes the result.
// While the receiver stalls with a result pending, in_ready_o is low and the
// sequencer holds; it resumes as soon as the pending result is taken.
// State reset: idle, prog high, clock/data low, status 0, no result pending.
// Config registers (APB, byte address 4*index) reset to 10, 5, 200, 0xFFFFFF
// and 50 and should be written only while the block is idle.
module fpga_serial_config_loader
  import fscl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          byte_value_i,
  input  logic                init_level_i,
  input  logic                done_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                prog_pin_o,
  output logic                clock_pin_o,
  output logic                data_pin_o,
  output logic                ready_for_byte_o,
  output logic                busy_res_o,
  output logic                rejected_o,
  output logic [2:0]          status_o
);

  cfg_t cfg;

  fscl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phase_e      phase_q, phase_d, phase_cur;
  logic [23:0] tick_q, tick_d, tick_inc;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  half_q, half_d;
  logic        prog_q, prog_d, clk_q, clk_d, data_q, data_d;
  logic [2:0]  status_q, status_d;
  logic        out_valid_q;
  logic        rej;
  logic        can_take;
  logic        accept;
  mode_e       mode;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tick_inc   = tick_q + 24'd1;

  always_comb begin
    unique case (phase_q)
      PH_IDLE, PH_PROG_HIGH, PH_SETTLE_A, PH_INIT_LOW, PH_SETTLE_B,
      PH_INIT_HIGH, PH_LOAD, PH_DONE_LOW, PH_DONE_HIGH: phase_cur = phase_q;
      default: phase_cur = PH_IDLE;
    endcase
  end

  always_comb begin
    phase_d  = phase_cur;
    tick_d   = tick_q;
    shift_d  = shift_q;
    half_d   = half_q;
    prog_d   = prog_q;
    clk_d    = clk_q;
    data_d   = data_q;
    status_d = status_q;
    can_take = (phase_cur == PH_LOAD) && (half_q == 4'd0);
    rej      = ((mode == MODE_START) && (phase_cur != PH_IDLE)) ||
               (((mode == MODE_BYTE) || (mode == MODE_FINISH)) && !can_take);

    unique case (phase_cur)
      PH_IDLE: begin
        if (mode == MODE_START) begin
          clk_d    = 1'b0;
          prog_d   = 1'b1;
          tick_d   = '0;
          status_d = StatusNone;
          phase_d  = PH_PROG_HIGH;
        end
      end
      PH_PROG_HIGH: begin
        tick_d = tick_inc;
        if (tick_inc >= {16'd0, cfg.prog_high_ticks}) begin
          prog_d  = 1'b0;
          tick_d  = '0;
          phase_d = PH_SETTLE_A;
        end
      end
      PH_SETTLE_A: begin
        tick_d = tick_inc;
        if (tick_inc >= {16'd0, cfg.settle_ticks}) begin
          tick_d  = '0;
          phase_d = PH_INIT_LOW;
        end
      end
      PH_INIT_LOW: begin
        if (!init_level_i) begin
          tick_d  = '0;
          phase_d = PH_SETTLE_B;
        end else begin
          tick_d = tick_inc;
          if (tick_inc >= {8'd0, cfg.init_low_timeout}) begin
            prog_d   = 1'b1;
            status_d = StatusInitLowTo;
            phase_d  = PH_IDLE;
          end
        end
      end
      PH_SETTLE_B: begin
        tick_d = tick_inc;
        if (tick_inc >= {16'd0, cfg.settle_ticks}) begin
          prog_d  = 1'b1;
          tick_d  = '0;
          phase_d = PH_INIT_HIGH;
        end
      end
      PH_INIT_HIGH: begin
        if (init_level_i) begin
          tick_d  = '0;
          half_d  = '0;
          phase_d = PH_LOAD;
        end else begin
          tick_d = tick_inc;
          if (tick_inc >= cfg.init_high_timeout) begin
            status_d = StatusInitHiTo;
            phase_d  = PH_IDLE;
          end
        end
      end
      PH_LOAD: begin
        if (half_q != 4'd0) begin
          if (half_q[0]) begin
            clk_d   = 1'b1;
            shift_d = {shift_q[6:0], 1'b0};
          end else begin
            clk_d  = 1'b0;
            data_d = shift_q[7];
          end
          half_d = half_q - 4'd1;
        end else if (mode == MODE_BYTE) begin
          shift_d = byte_value_i;
          clk_d   = 1'b0;
          data_d  = byte_value_i[7];
          half_d  = 4'd15;
        end else if (mode == MODE_FINISH) begin
          tick_d  = '0;
          phase_d = PH_DONE_LOW;
        end
      end
      PH_DONE_LOW: begin
        clk_d = 1'b0;
        if (done_level_i || (tick_q >= {16'd0, cfg.done_clock_limit})) begin
          data_d   = 1'b1;
          status_d = done_level_i ? StatusOk : StatusDoneTo;
          phase_d  = PH_IDLE;
        end else begin
          phase_d = PH_DONE_HIGH;
        end
      end
      PH_DONE_HIGH: begin
        clk_d   = 1'b1;
        tick_d  = tick_inc;
        phase_d = PH_DONE_LOW;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      shift_q  <= '0;
      half_q   <= '0;
      prog_q   <= 1'b1;
      clk_q    <= 1'b0;
      data_q   <= 1'b0;
      status_q <= StatusNone;
    end else if (accept) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      shift_q  <= shift_d;
      half_q   <= half_d;
      prog_q   <= prog_d;
      clk_q    <= clk_d;
      data_q   <= data_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prog_pin_o       <= prog_d;
      clock_pin_o      <= clk_d;
      data_pin_o       <= data_d;
      ready_for_byte_o <= (phase_d == PH_LOAD) && (half_d == 4'd0);
      busy_res_o       <= (phase_d != PH_IDLE);
      rejected_o       <= rej;
      status_o         <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/fscl_checker.sv @@
module fscl_checker
  import fscl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       ready_for_byte_o,
  input logic       busy_res_o,
  input logic [2:0] status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(busy_res_o))
    else $error("result dropped or changed while stalled");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with output register free");

  a_rfb_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ready_for_byte_o |-> busy_res_o)
    else $error("ready for byte while not busy");

  a_busy_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && busy_res_o |-> status_o == StatusNone)
    else $error("final status reported during a running sequence");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("config port not ready");

endmodule

bind fpga_serial_config_loader fscl_checker u_fscl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pready           (pready),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .ready_for_byte_o (ready_for_byte_o),
  .busy_res_o       (busy_res_o),
  .status_o         (status_o)
);
